FILE: hw/rtl/cbor_stream_decoder_assert.svh
// Assertion helpers for the CBOR stream decoder.
// Both sample on clk and are disabled while arst_n is low.
`ifndef CBOR_STREAM_DECODER_ASSERT_SVH
`define CBOR_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define CBSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cbsd_pkg.sv
`timescale 1ns / 1ps

package cbsd_pkg;

	typedef enum logic [3:0] {
		EV_POS        = 4'd0,
		EV_NEG        = 4'd1,
		EV_BYTES      = 4'd2,
		EV_TEXT       = 4'd3,
		EV_ARRAY      = 4'd4,
		EV_MAP        = 4'd5,
		EV_TAG        = 4'd6,
		EV_SIMPLE     = 4'd7,
		EV_FLOAT      = 4'd8,
		EV_BREAK      = 4'd9,
		EV_BYTE_PIECE = 4'd10,
		EV_TEXT_PIECE = 4'd11,
		EV_ERROR      = 4'd12
	} ev_kind_t;

	// log2 of the argument width in bytes
	localparam logic [1:0] LG_HALF   = 2'd1;
	localparam logic [1:0] LG_SINGLE = 2'd2;

	// additional-information codes
	localparam logic [4:0] AI_IMM_MAX = 5'd23;
	localparam logic [4:0] AI_ARG1    = 5'd24;
	localparam logic [4:0] AI_ARG8    = 5'd27;
	localparam logic [4:0] AI_INDEF   = 5'd31;

	localparam logic [2:0] MT_POS     = 3'd0;
	localparam logic [2:0] MT_NEG     = 3'd1;
	localparam logic [2:0] MT_BSTR    = 3'd2;
	localparam logic [2:0] MT_TSTR    = 3'd3;
	localparam logic [2:0] MT_ARRAY   = 3'd4;
	localparam logic [2:0] MT_MAP     = 3'd5;
	localparam logic [2:0] MT_SIMPLE  = 3'd7;

	localparam logic [7:0] BREAK_BYTE = 8'hFF;

endpackage

FILE: hw/rtl/cbor_stream_decoder.sv
`timescale 1ns / 1ps

// channel | signals                         | direction | beat
// --------+---------------------------------+-----------+------------------------------
// in      | in_valid, in_ready, data_byte   | sink      | one CBOR byte
// out     | out_valid, out_ready, event_kind| source    | one event: event_kind, value,
//         | value, indefinite,              |           | indefinite, piece_has_byte,
//         | piece_has_byte, piece_last      |           | piece_last
//
// One byte per cycle while in_ready is high; an event is valid the cycle after its byte.
// The parse state and the event are updated in the same cycle; the longest path is the
// float widening on the last argument byte of a half or single.
// in_ready is low only while an event is held in the output register and out_ready is low.
// arst_n clears the parse phase and the output valid; no clearing pass is needed.
module cbor_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [63:0] value,
	output logic        indefinite,
	output logic        piece_has_byte,
	output logic        piece_last
);

	`include "cbor_stream_decoder_assert.svh"

	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_ARG_POS     = 5'd1,
		PH_ARG_NEG     = 5'd2,
		PH_ARG_BLEN    = 5'd3,
		PH_ARG_TLEN    = 5'd4,
		PH_ARG_ARRAY   = 5'd5,
		PH_ARG_MAP     = 5'd6,
		PH_ARG_TAG     = 5'd7,
		PH_ARG_FLOAT   = 5'd8,
		PH_SIMPLE      = 5'd9,
		PH_BYTES       = 5'd10,
		PH_TEXT        = 5'd11,
		PH_BINDEF      = 5'd12,
		PH_TINDEF      = 5'd13,
		PH_BCHUNK_LEN  = 5'd14,
		PH_TCHUNK_LEN  = 5'd15,
		PH_BCHUNK      = 5'd16,
		PH_TCHUNK      = 5'd17,
		PH_FAILED      = 5'd18
	} phase_t;

	phase_t             ph_q, ph_d;
	logic [1:0]         lg_q, lg_d;
	logic [63:0]        br_q, br_d;
	logic [63:0]        acc_q, acc_d;

	logic               valid_q;
	cbsd_pkg::ev_kind_t kind_q, kind_d;
	logic [63:0]        val_q, val_d;
	logic               indef_q, indef_d;
	logic               has_q, has_d;
	logic               last_q, last_d;
	logic               emit;

	logic               accept;
	logic [2:0]         major;
	logic [4:0]         low;
	logic [63:0]        acc_shift;
	logic [63:0]        br_dec;
	logic [63:0]        float_bits;
	logic [3:0]         width_bytes;

	assign in_ready   = !valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign major      = data_byte[7:5];
	assign low        = data_byte[4:0];
	assign acc_shift  = {acc_q[55:0], data_byte};
	assign br_dec     = (br_q == 64'd0) ? 64'd0 : br_q - 64'd1;
	assign width_bytes = 4'd1 << low[1:0];

	cbsd_float_widen u_widen (
		.acc  (acc_shift),
		.lg   (lg_q),
		.bits (float_bits)
	);

	always_comb begin
		ph_d    = ph_q;
		lg_d    = lg_q;
		br_d    = br_q;
		acc_d   = acc_q;
		emit    = 1'b0;
		kind_d  = cbsd_pkg::EV_POS;
		val_d   = 64'd0;
		indef_d = 1'b0;
		has_d   = 1'b0;
		last_d  = 1'b0;

		case (ph_q)
			PH_IDLE: begin
				if (major == cbsd_pkg::MT_SIMPLE) begin
					if (low <= cbsd_pkg::AI_IMM_MAX) begin
						emit   = 1'b1;
						kind_d = cbsd_pkg::EV_SIMPLE;
						val_d  = {59'd0, low};
					end else if (low == cbsd_pkg::AI_ARG1) begin
						ph_d = PH_SIMPLE;
					end else if (low <= cbsd_pkg::AI_ARG8) begin
						ph_d  = PH_ARG_FLOAT;
						lg_d  = low[1:0];
						br_d  = {60'd0, width_bytes};
						acc_d = 64'd0;
					end else if (low == cbsd_pkg::AI_INDEF) begin
						emit   = 1'b1;
						kind_d = cbsd_pkg::EV_BREAK;
					end
				end else if (low inside {[cbsd_pkg::AI_ARG1 : cbsd_pkg::AI_ARG8]}) begin
					lg_d  = low[1:0];
					br_d  = {60'd0, width_bytes};
					acc_d = 64'd0;
					case (major)
						cbsd_pkg::MT_POS:   ph_d = PH_ARG_POS;
						cbsd_pkg::MT_NEG:   ph_d = PH_ARG_NEG;
						cbsd_pkg::MT_BSTR:  ph_d = PH_ARG_BLEN;
						cbsd_pkg::MT_TSTR:  ph_d = PH_ARG_TLEN;
						cbsd_pkg::MT_ARRAY: ph_d = PH_ARG_ARRAY;
						cbsd_pkg::MT_MAP:   ph_d = PH_ARG_MAP;
						default:            ph_d = PH_ARG_TAG;
					endcase
				end else if (low <= cbsd_pkg::AI_IMM_MAX) begin
					if (low != 5'd0 && major == cbsd_pkg::MT_BSTR) begin
						br_d = {59'd0, low};
						ph_d = PH_BYTES;
					end else if (low != 5'd0 && major == cbsd_pkg::MT_TSTR) begin
						br_d = {59'd0, low};
						ph_d = PH_TEXT;
					end
					emit   = 1'b1;
					kind_d = cbsd_pkg::ev_kind_t'({1'b0, major});
					val_d  = {59'd0, low};
				end else if (low == cbsd_pkg::AI_INDEF && major >= cbsd_pkg::MT_BSTR
						&& major <= cbsd_pkg::MT_MAP) begin
					if (major == cbsd_pkg::MT_BSTR) begin
						ph_d = PH_BINDEF;
					end else if (major == cbsd_pkg::MT_TSTR) begin
						ph_d = PH_TINDEF;
					end
					emit    = 1'b1;
					kind_d  = cbsd_pkg::ev_kind_t'({1'b0, major});
					indef_d = 1'b1;
				end
			end
			PH_ARG_POS, PH_ARG_NEG, PH_ARG_BLEN, PH_ARG_TLEN, PH_ARG_ARRAY,
			PH_ARG_MAP, PH_ARG_TAG, PH_ARG_FLOAT, PH_BCHUNK_LEN, PH_TCHUNK_LEN: begin
				acc_d = acc_shift;
				br_d  = br_dec;
				if (br_dec == 64'd0) begin
					ph_d  = PH_IDLE;
					emit  = 1'b1;
					val_d = acc_shift;
					case (ph_q)
						PH_ARG_POS:   kind_d = cbsd_pkg::EV_POS;
						PH_ARG_NEG:   kind_d = cbsd_pkg::EV_NEG;
						PH_ARG_BLEN: begin
							kind_d = cbsd_pkg::EV_BYTES;
							if (acc_shift != 64'd0) begin
								br_d = acc_shift;
								ph_d = PH_BYTES;
							end
						end
						PH_ARG_TLEN: begin
							kind_d = cbsd_pkg::EV_TEXT;
							if (acc_shift != 64'd0) begin
								br_d = acc_shift;
								ph_d = PH_TEXT;
							end
						end
						PH_ARG_ARRAY: kind_d = cbsd_pkg::EV_ARRAY;
						PH_ARG_MAP:   kind_d = cbsd_pkg::EV_MAP;
						PH_ARG_TAG:   kind_d = cbsd_pkg::EV_TAG;
						PH_ARG_FLOAT: begin
							kind_d = cbsd_pkg::EV_FLOAT;
							val_d  = float_bits;
						end
						PH_BCHUNK_LEN: begin
							emit = 1'b0;
							if (acc_shift != 64'd0) begin
								br_d = acc_shift;
								ph_d = PH_BCHUNK;
							end else begin
								ph_d = PH_BINDEF;
							end
						end
						default: begin
							emit = 1'b0;
							if (acc_shift != 64'd0) begin
								br_d = acc_shift;
								ph_d = PH_TCHUNK;
							end else begin
								ph_d = PH_TINDEF;
							end
						end
					endcase
				end
			end
			PH_SIMPLE: begin
				ph_d   = PH_IDLE;
				emit   = 1'b1;
				kind_d = cbsd_pkg::EV_SIMPLE;
				val_d  = {56'd0, data_byte};
			end
			PH_BYTES, PH_TEXT, PH_BCHUNK, PH_TCHUNK: begin
				br_d = br_dec;
				if (br_dec == 64'd0) begin
					case (ph_q)
						PH_BCHUNK: ph_d = PH_BINDEF;
						PH_TCHUNK: ph_d = PH_TINDEF;
						default:   ph_d = PH_IDLE;
					endcase
				end
				emit   = 1'b1;
				kind_d = (ph_q == PH_BYTES || ph_q == PH_BCHUNK) ?
					cbsd_pkg::EV_BYTE_PIECE : cbsd_pkg::EV_TEXT_PIECE;
				val_d  = {56'd0, data_byte};
				has_d  = 1'b1;
				last_d = (br_q <= 64'd1);
			end
			PH_BINDEF, PH_TINDEF: begin
				if (major == ((ph_q == PH_BINDEF) ? cbsd_pkg::MT_BSTR : cbsd_pkg::MT_TSTR)
						&& low <= cbsd_pkg::AI_ARG8) begin
					if (low >= cbsd_pkg::AI_ARG1) begin
						lg_d  = low[1:0];
						br_d  = {60'd0, width_bytes};
						acc_d = 64'd0;
						ph_d  = (ph_q == PH_BINDEF) ? PH_BCHUNK_LEN : PH_TCHUNK_LEN;
					end else if (low != 5'd0) begin
						br_d = {59'd0, low};
						ph_d = (ph_q == PH_BINDEF) ? PH_BCHUNK : PH_TCHUNK;
					end
				end else if (data_byte == cbsd_pkg::BREAK_BYTE) begin
					ph_d   = PH_IDLE;
					emit   = 1'b1;
					kind_d = (ph_q == PH_BINDEF) ?
						cbsd_pkg::EV_BYTE_PIECE : cbsd_pkg::EV_TEXT_PIECE;
				end else begin
					ph_d   = PH_FAILED;
					emit   = 1'b1;
					kind_d = cbsd_pkg::EV_ERROR;
				end
			end
			default: begin
				ph_d   = PH_FAILED;
				emit   = 1'b1;
				kind_d = cbsd_pkg::EV_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			lg_q    <= 2'd0;
			br_q    <= 64'd0;
			acc_q   <= 64'd0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				ph_q    <= ph_d;
				lg_q    <= lg_d;
				br_q    <= br_d;
				acc_q   <= acc_d;
				valid_q <= emit;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q  <= kind_d;
			val_q   <= val_d;
			indef_q <= indef_d;
			has_q   <= has_d;
			last_q  <= last_d;
		end
	end

	assign out_valid      = valid_q;
	assign event_kind     = 4'(kind_q);
	assign value          = val_q;
	assign indefinite     = indef_q;
	assign piece_has_byte = has_q;
	assign piece_last     = last_q;

	`CBSD_ASSERT_NEXT(a_failed_sticky, ph_q == PH_FAILED, ph_q == PH_FAILED,
		"error phase left without reset")
	`CBSD_ASSERT_NOW(a_arg_count, ph_q == PH_ARG_POS || ph_q == PH_ARG_FLOAT
		|| ph_q == PH_BCHUNK_LEN || ph_q == PH_TCHUNK_LEN,
		br_q != 64'd0 && br_q <= 64'd8, "argument byte count out of range")
	`CBSD_ASSERT_NOW(a_piece_flags, valid_q && kind_q != cbsd_pkg::EV_BYTE_PIECE
		&& kind_q != cbsd_pkg::EV_TEXT_PIECE, !has_q && !last_q,
		"piece flags on a non-piece event")
	`CBSD_ASSERT_NOW(a_last_has_byte, valid_q && last_q, has_q,
		"last flag on an end piece")
	`CBSD_ASSERT_NOW(a_indef_header, valid_q && indef_q, val_q == 64'd0
		&& (kind_q == cbsd_pkg::EV_BYTES || kind_q == cbsd_pkg::EV_TEXT
		|| kind_q == cbsd_pkg::EV_ARRAY || kind_q == cbsd_pkg::EV_MAP),
		"indefinite flag on a bad event")

endmodule

FILE: hw/rtl/cbsd_float_widen.sv
`timescale 1ns / 1ps

// Exact half/single to double widening, NaNs aside.
module cbsd_float_widen (
	input  logic [63:0] acc,
	input  logic [1:0]  lg,
	output logic [63:0] bits
);

	logic        hs;
	logic [4:0]  he;
	logic [9:0]  hm;
	logic [3:0]  hp;
	logic        ss;
	logic [7:0]  se;
	logic [22:0] sm;
	logic [4:0]  sp;
	logic [51:0] hfrac;
	logic [51:0] sfrac;

	always_comb begin
		hs = acc[15];
		he = acc[14:10];
		hm = acc[9:0];
		ss = acc[31];
		se = acc[30:23];
		sm = acc[22:0];

		// leading one of a subnormal mantissa
		hp = '0;
		for (int i = 0; i < 10; i++) begin
			if (hm[i]) begin
				hp = 4'(i);
			end
		end
		sp = '0;
		for (int i = 0; i < 23; i++) begin
			if (sm[i]) begin
				sp = 5'(i);
			end
		end

		hfrac = {42'd0, hm} << (6'd52 - {2'd0, hp});
		sfrac = {29'd0, sm} << (6'd52 - {1'b0, sp});

		if (lg == cbsd_pkg::LG_HALF) begin
			if (he == 5'd0) begin
				if (hm == 10'd0) begin
					bits = {hs, 63'd0};
				end else begin
					bits = {hs, 11'(hp) + 11'd999, hfrac};
				end
			end else if (he == 5'h1F) begin
				bits = {hs, 11'h7FF, (hm != 10'd0), 51'd0};
			end else begin
				bits = {hs, 11'(he) + 11'd1008, hm, 42'd0};
			end
		end else if (lg == cbsd_pkg::LG_SINGLE) begin
			if (se == 8'd0) begin
				if (sm == 23'd0) begin
					bits = {ss, 63'd0};
				end else begin
					bits = {ss, 11'(sp) + 11'd874, sfrac};
				end
			end else if (se == 8'hFF) begin
				bits = {ss, 11'h7FF, sm[22] | (sm != 23'd0), sm[21:0], 29'd0};
			end else begin
				bits = {ss, 11'(se) + 11'd896, sm, 29'd0};
			end
		end else begin
			bits = acc;
		end
	end

endmodule
